>>> hdl/tkgb_pkg.sv
// Shared register indexes, command codes and types for the tilt Kalman gyro bias unit.
package tkgb_pkg;
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_TIME   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ANGLE_NOISE = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BIAS_NOISE  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MEAS_NOISE  = 2'd3;

    localparam logic CMD_PREDICT = 1'b0;
    localparam logic CMD_CORRECT = 1'b1;

    // Divider request from the sequencer.
    typedef struct packed {
        logic start;
        logic neg;
    } div_ctl_t;
endpackage

>>> hdl/tilt_kalman_gyro_bias_unit.sv
// Two-state angle and gyro bias Kalman filter with a shared multiplier and divider.
// Predict steps through its multiply states; correct runs two serial divisions first,
// which a zero divisor skips. One item at a time; s_tready rises once the result is taken.
// aresetn is synchronous, active low; it restores the register defaults, zeroes angle,
// bias and rate, and sets covariance to identity.
module tilt_kalman_gyro_bias_unit
    import tkgb_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 24
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [WORD_BITS-1:0] s_tdata,   // sample
    input  logic                 s_tuser,   // cmd
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [3*WORD_BITS-1:0] m_tdata, // bias_est (top), rate_est, angle_est (bottom)
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [FRAC_BITS:0]   cfg_data
);
    localparam int W  = WORD_BITS;
    localparam int CW = FRAC_BITS + 1;
    localparam logic signed [W-1:0] ONE = W'(1) <<< FRAC_BITS;
    localparam logic signed [W+1:0] PMAX = {3'b000, {(W-1){1'b1}}};
    localparam logic signed [W+1:0] NMIN = {3'b111, {(W-1){1'b0}}};

    localparam logic [4:0] S_IDLE = 5'd0,  S_P0 = 5'd1,  S_P1 = 5'd2,  S_P2 = 5'd3,
                           S_P3 = 5'd4,  S_P4 = 5'd5,  S_P5 = 5'd6,  S_C0 = 5'd7,
                           S_CD0 = 5'd8, S_CD1 = 5'd9, S_CM0 = 5'd10, S_CM1 = 5'd11,
                           S_CM2 = 5'd12, S_CM3 = 5'd13, S_CM4 = 5'd14, S_CM5 = 5'd15,
                           S_OUT = 5'd16, S_MW = 5'd17;

    logic [4:0] st_reg, st_next, ret_reg, ret_next;
    logic [CW-1:0] dt_reg, qa_reg, qb_reg, r_reg;
    logic signed [W-1:0] ang_reg, bias_reg, rate_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [W-1:0] smp_reg, err_reg, e_reg, k0_reg, k1_reg, d1_reg;
    logic signed [W-1:0] ma_reg, mb_reg, prod_reg;
    logic [3*W-1:0]      out_reg;
    logic                ov_reg;

    function automatic logic signed [W-1:0] sat2(input logic signed [W+1:0] v);
        if (v > PMAX) return PMAX[W-1:0];
        if (v < NMIN) return NMIN[W-1:0];
        return v[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] add_s(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
        return sat2({{2{a[W-1]}}, a} + {{2{b[W-1]}}, b});
    endfunction

    function automatic logic signed [W-1:0] sub_s(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
        return sat2({{2{a[W-1]}}, a} - {{2{b[W-1]}}, b});
    endfunction

    // Shared multiplier: magnitude product, round half away, saturate.
    logic [W-1:0]    ua, ub;
    logic [2*W-1:0]  up;
    logic [2*W-1:0]  ur;
    logic            mneg;
    logic [W:0]      mlim;
    logic [2*W-1:0]  mmag;
    logic signed [W-1:0] mres;
    always_comb begin
        mneg = ma_reg[W-1] ^ mb_reg[W-1];
        ua   = ma_reg[W-1] ? W'(-ma_reg) : ma_reg;
        ub   = mb_reg[W-1] ? W'(-mb_reg) : mb_reg;
        up   = ua * ub;
        ur   = (up + ((2*W)'(1) << (FRAC_BITS-1))) >> FRAC_BITS;
        mlim = mneg ? {2'b01, {(W-1){1'b0}}} : {2'b00, {(W-1){1'b1}}};
        mmag = (ur > {{(W-1){1'b0}}, mlim}) ? {{(W-1){1'b0}}, mlim} : ur;
        mres = mneg ? W'(-mmag) : mmag[W-1:0];
    end

    div_ctl_t            dctl;
    logic [W-1:0]        dnum, dden;
    logic                ddone;
    logic signed [W-1:0] dq;
    tkgb_div #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
        .aclk(aclk), .aresetn(aresetn), .ctl(dctl), .num_mag(dnum), .den_mag(dden),
        .done(ddone), .quot(dq)
    );

    assign dden = e_reg[W-1] ? W'(-e_reg) : e_reg;
    assign dnum = (st_reg == S_CD0) ? (p00_reg[W-1] ? W'(-p00_reg) : p00_reg)
                                    : (p10_reg[W-1] ? W'(-p10_reg) : p10_reg);

    assign s_tready  = (st_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = ov_reg;
    assign m_tdata   = out_reg;

    always_comb begin
        st_next  = st_reg;
        ret_next = ret_reg;
        dctl     = '{start: 1'b0, neg: 1'b0};
        case (st_reg)
            S_IDLE: if (s_tvalid) st_next = s_tuser ? S_C0 : S_P0;
            S_P0, S_P1, S_P2, S_P3, S_P4: st_next = st_reg + 5'd1;
            S_P5: st_next = S_OUT;
            S_C0: st_next = (add_s(p00_reg, W'(r_reg)) == '0) ? S_OUT : S_CD0;
            S_CD0: begin
                if (ret_reg == S_IDLE) begin
                    dctl = '{start: 1'b1, neg: p00_reg[W-1] ^ e_reg[W-1]};
                    ret_next = S_CD0;
                end else if (ddone) begin
                    ret_next = S_IDLE;
                    st_next  = S_CD1;
                end
            end
            S_CD1: begin
                if (ret_reg == S_IDLE) begin
                    dctl = '{start: 1'b1, neg: p10_reg[W-1] ^ e_reg[W-1]};
                    ret_next = S_CD1;
                end else if (ddone) begin
                    ret_next = S_IDLE;
                    st_next  = S_CM0;
                end
            end
            S_CM0, S_CM1, S_CM2, S_CM3, S_CM4: st_next = st_reg + 5'd1;
            S_CM5: st_next = S_OUT;
            S_OUT: st_next = S_MW;
            S_MW:  if (!ov_reg || m_tready) st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= S_IDLE;
            ret_reg  <= S_IDLE;
            ov_reg   <= 1'b0;
            dt_reg   <= CW'(335544);
            qa_reg   <= CW'(16777);
            qb_reg   <= CW'(25166);
            r_reg    <= CW'(16777);
            ang_reg  <= '0;
            bias_reg <= '0;
            rate_reg <= '0;
            p00_reg  <= ONE;
            p01_reg  <= '0;
            p10_reg  <= '0;
            p11_reg  <= ONE;
        end else begin
            st_reg  <= st_next;
            ret_reg <= ret_next;
            if (ov_reg && m_tready) ov_reg <= 1'b0;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_STEP_TIME:   dt_reg <= cfg_data;
                    CFG_ANGLE_NOISE: qa_reg <= cfg_data;
                    CFG_BIAS_NOISE:  qb_reg <= cfg_data;
                    CFG_MEAS_NOISE:  r_reg  <= cfg_data;
                    default: ;
                endcase
            end
            // The multiplier operands are loaded one state ahead of their use.
            case (st_reg)
                S_IDLE: if (s_tvalid) smp_reg <= s_tdata;
                S_P0: begin
                    rate_reg <= sub_s(smp_reg, bias_reg);
                    ma_reg   <= sub_s(smp_reg, bias_reg);
                    mb_reg   <= W'(dt_reg);
                    d1_reg   <= sat2(-{{2{p11_reg[W-1]}}, p11_reg});
                end
                S_P1: begin
                    ang_reg <= add_s(ang_reg, mres);
                    ma_reg  <= sat2({2'b00, W'(qa_reg)} - {{2{p01_reg[W-1]}}, p01_reg}
                                    - {{2{p10_reg[W-1]}}, p10_reg});
                end
                S_P2: begin
                    p00_reg <= add_s(p00_reg, mres);
                    ma_reg  <= d1_reg;
                end
                S_P3: prod_reg <= mres;
                S_P4: begin
                    p01_reg <= add_s(p01_reg, prod_reg);
                    p10_reg <= add_s(p10_reg, prod_reg);
                    ma_reg  <= W'(qb_reg);
                end
                S_P5: p11_reg <= add_s(p11_reg, mres);
                S_C0: begin
                    err_reg <= sub_s(smp_reg, ang_reg);
                    e_reg   <= add_s(p00_reg, W'(r_reg));
                end
                S_CD0: if (ddone) k0_reg <= dq;
                // The k1 terms go first so that cov_00 and cov_01 still hold old values.
                S_CD1: if (ddone) begin
                    k1_reg <= dq;
                    ma_reg <= dq;
                    mb_reg <= p00_reg;
                end
                S_CM0: begin
                    p10_reg <= sub_s(p10_reg, mres);
                    mb_reg  <= p01_reg;
                end
                S_CM1: begin
                    p11_reg <= sub_s(p11_reg, mres);
                    ma_reg  <= k0_reg;
                    mb_reg  <= p00_reg;
                end
                S_CM2: begin
                    p00_reg <= sub_s(p00_reg, mres);
                    mb_reg  <= p01_reg;
                end
                S_CM3: begin
                    p01_reg <= sub_s(p01_reg, mres);
                    mb_reg  <= err_reg;
                end
                S_CM4: begin
                    ang_reg <= add_s(ang_reg, mres);
                    ma_reg  <= k1_reg;
                end
                S_CM5: bias_reg <= add_s(bias_reg, mres);
                S_OUT: begin
                    out_reg <= {bias_reg, rate_reg, ang_reg};
                    ov_reg  <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("took a second request while busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("ready for a request while a result waits");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == S_OUT) |=> m_tvalid)
        else $error("result not presented");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("waiting result changed");
endmodule

>>> hdl/tkgb_div.sv
// Restoring radix-2 divider for rounded, saturated fixed-point quotients.
module tkgb_div
    import tkgb_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 24
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  div_ctl_t                    ctl,
    input  logic [WORD_BITS-1:0]        num_mag,
    input  logic [WORD_BITS-1:0]        den_mag,
    output logic                        done,
    output logic signed [WORD_BITS-1:0] quot
);
    localparam int NB = WORD_BITS + FRAC_BITS + 1;
    localparam int CB = $clog2(NB + 1);
    localparam logic [WORD_BITS:0] NEG_LIM = {2'b01, {(WORD_BITS-1){1'b0}}};
    localparam logic [WORD_BITS:0] POS_LIM = {2'b00, {(WORD_BITS-1){1'b1}}};

    logic [NB-1:0]      dvd_reg, dvd_next;
    logic [WORD_BITS:0] rem_reg, rem_next;
    logic [WORD_BITS:0] q_reg, q_next;
    logic               over_reg, over_next;
    logic               neg_reg, neg_next;
    logic               busy_reg, busy_next;
    logic [CB-1:0]      cnt_reg, cnt_next;
    logic [WORD_BITS:0] shifted;
    logic               qb;
    logic [WORD_BITS:0] lim;
    logic [WORD_BITS:0] mag_r;

    always_comb begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        over_next = over_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        shifted   = {rem_reg[WORD_BITS-1:0], dvd_reg[NB-1]};
        qb        = (shifted >= {1'b0, den_mag});
        done      = 1'b0;
        if (ctl.start) begin
            // Dividend with rounding: (n << FRAC) + d/2.
            dvd_next  = ({{(FRAC_BITS+1){1'b0}}, num_mag} << FRAC_BITS)
                        + {{(FRAC_BITS+2){1'b0}}, den_mag[WORD_BITS-1:1]};
            rem_next  = '0;
            q_next    = '0;
            over_next = 1'b0;
            neg_next  = ctl.neg;
            busy_next = 1'b1;
            cnt_next  = CB'(NB);
        end else if (busy_reg) begin
            rem_next = qb ? shifted - {1'b0, den_mag} : shifted;
            dvd_next = {dvd_reg[NB-2:0], 1'b0};
            if (!over_reg) begin
                q_next = {q_reg[WORD_BITS-1:0], qb};
                if ({q_reg[WORD_BITS-1:0], qb} > NEG_LIM || q_reg[WORD_BITS])
                    over_next = 1'b1;
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CB'(1)) begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    always_comb begin
        lim   = neg_reg ? NEG_LIM : POS_LIM;
        mag_r = (over_next || q_next > lim) ? lim : q_next;
        quot  = neg_reg ? WORD_BITS'(-mag_r) : mag_r[WORD_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        over_reg <= over_next;
        neg_reg  <= neg_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn) done |-> busy_reg)
        else $error("divider done while idle");
    assert property (@(posedge aclk) disable iff (!aresetn) ctl.start |=> busy_reg)
        else $error("divider did not start");
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg != '0)
        else $error("divider count underflow");
endmodule

>>> tb/tb_tilt_kalman_gyro_bias_unit.sv
// Self-checking testbench for the tilt Kalman gyro bias unit with an internal filter model.
module tb_tilt_kalman_gyro_bias_unit;
    import tkgb_pkg::*;

    localparam int  WORD_BITS = 32;
    localparam int  FRAC_BITS = 24;
    localparam longint POS_LIM = (longint'(1) << (WORD_BITS - 1)) - 1;
    localparam longint NEG_LIM = longint'(1) << (WORD_BITS - 1);
    localparam longint ONE_FX = longint'(1) << FRAC_BITS;
    localparam int  STALL_LIMIT = 4000;

    typedef struct {
        logic                 cmd;
        logic [WORD_BITS-1:0] sample;
    } sensor_req_t;

    typedef struct {
        logic [WORD_BITS-1:0] angle;
        logic [WORD_BITS-1:0] rate;
        logic [WORD_BITS-1:0] bias;
    } estimate_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [WORD_BITS-1:0] s_tdata = '0;
    logic s_tuser = CMD_PREDICT;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [3*WORD_BITS-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = CFG_STEP_TIME;
    logic [FRAC_BITS:0] cfg_data = '0;

    sensor_req_t pending_reqs[$];
    estimate_t   expected_estimates[$];

    // Filter state held by the testbench.
    longint dt_q, q_angle_q, q_bias_q, r_meas_q;
    longint angle_q, bias_q, rate_q, p00_q, p01_q, p10_q, p11_q;

    int  errors = 0;
    int  req_count = 0;
    int  est_count = 0;
    int  corrections = 0;
    int  phases = 0;
    int  idle_count = 0;
    bit  calm = 1'b0;
    int  s_gap = 0;
    int  m_gap = 0;

    tilt_kalman_gyro_bias_unit #(
        .WORD_BITS(WORD_BITS),
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic longint clamp_word(longint v);
        if (v > POS_LIM) return POS_LIM;
        if (v < -NEG_LIM) return -NEG_LIM;
        return v;
    endfunction

    // Fixed-point product, rounded half away from zero, saturated.
    function automatic longint fx_product(longint a, longint b);
        logic [127:0] ua, ub, p, lim;
        bit neg;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? 128'(-a) : 128'(a);
        ub = (b < 0) ? 128'(-b) : 128'(b);
        p = ((ua * ub) + (128'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        lim = neg ? 128'(NEG_LIM) : 128'(POS_LIM);
        if (p > lim) p = lim;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    // Fixed-point quotient, rounded half away from zero, saturated; d is nonzero.
    function automatic longint fx_quotient(longint n, longint d);
        logic [127:0] un, ud, q, lim;
        bit neg;
        neg = (n < 0) != (d < 0);
        un = (n < 0) ? 128'(-n) : 128'(n);
        ud = (d < 0) ? 128'(-d) : 128'(d);
        q = ((un << FRAC_BITS) + (ud >> 1)) / ud;
        lim = neg ? 128'(NEG_LIM) : 128'(POS_LIM);
        if (q > lim) q = lim;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic void reset_filter();
        dt_q = 335544; q_angle_q = 16777; q_bias_q = 25166; r_meas_q = 16777;
        angle_q = 0; bias_q = 0; rate_q = 0;
        p00_q = ONE_FX; p01_q = 0; p10_q = 0; p11_q = ONE_FX;
    endfunction

    function automatic void apply_setting(logic [CFG_IDX_BITS-1:0] idx, logic [FRAC_BITS:0] val);
        case (idx)
            CFG_STEP_TIME:   dt_q = longint'(val);
            CFG_ANGLE_NOISE: q_angle_q = longint'(val);
            CFG_BIAS_NOISE:  q_bias_q = longint'(val);
            CFG_MEAS_NOISE:  r_meas_q = longint'(val);
            default: ;
        endcase
    endfunction

    // Advances the filter by one request and queues the estimate it should produce.
    function automatic void filter_step(sensor_req_t req);
        longint s, q, d0, d1, err, e, k0, k1, p00, p01;
        estimate_t est;
        s = longint'($signed(req.sample));
        if (req.cmd == CMD_PREDICT) begin
            q = clamp_word(s - bias_q);
            d0 = clamp_word(q_angle_q - p01_q - p10_q);
            d1 = clamp_word(-p11_q);
            rate_q = q;
            angle_q = clamp_word(angle_q + fx_product(q, dt_q));
            p00_q = clamp_word(p00_q + fx_product(d0, dt_q));
            p01_q = clamp_word(p01_q + fx_product(d1, dt_q));
            p10_q = clamp_word(p10_q + fx_product(d1, dt_q));
            p11_q = clamp_word(p11_q + fx_product(clamp_word(q_bias_q), dt_q));
        end else begin
            err = clamp_word(s - angle_q);
            e = clamp_word(p00_q + r_meas_q);
            if (e != 0) begin
                p00 = p00_q;
                p01 = p01_q;
                k0 = fx_quotient(p00, e);
                k1 = fx_quotient(p10_q, e);
                p00_q = clamp_word(p00 - fx_product(k0, p00));
                p01_q = clamp_word(p01 - fx_product(k0, p01));
                p10_q = clamp_word(p10_q - fx_product(k1, p00));
                p11_q = clamp_word(p11_q - fx_product(k1, p01));
                angle_q = clamp_word(angle_q + fx_product(k0, err));
                bias_q = clamp_word(bias_q + fx_product(k1, err));
            end
        end
        est.angle = angle_q[WORD_BITS-1:0];
        est.rate = rate_q[WORD_BITS-1:0];
        est.bias = bias_q[WORD_BITS-1:0];
        expected_estimates.push_back(est);
    endfunction

    task automatic report_mismatch(string what, logic [WORD_BITS-1:0] got,
                                   logic [WORD_BITS-1:0] want);
        $display("MISMATCH estimate %0d %s: got %h expected %h", est_count, what, got, want);
        errors++;
    endtask

    // Request driver.
    always @(posedge aclk) begin
        logic nv;
        nv = 1'b0;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                filter_step(pending_reqs.pop_front());
                req_count++;
            end
            if (s_tvalid && !s_tready) begin
                nv = 1'b1;
            end else if (s_gap > 0 && !calm) begin
                s_gap--;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                s_gap = $urandom_range(1, 15);
            end else if (pending_reqs.size() > 0) begin
                nv = 1'b1;
                s_tdata <= pending_reqs[0].sample;
                s_tuser <= pending_reqs[0].cmd;
            end
        end
        s_tvalid <= nv;
    end

    // Estimate monitor with random back-pressure.
    always @(posedge aclk) begin
        estimate_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_estimates.size() == 0) begin
                    report_mismatch("unexpected", m_tdata[WORD_BITS-1:0], '0);
                end else begin
                    want = expected_estimates.pop_front();
                    if (m_tdata[WORD_BITS-1:0] !== want.angle)
                        report_mismatch("angle", m_tdata[WORD_BITS-1:0], want.angle);
                    if (m_tdata[2*WORD_BITS-1:WORD_BITS] !== want.rate)
                        report_mismatch("rate", m_tdata[2*WORD_BITS-1:WORD_BITS], want.rate);
                    if (m_tdata[3*WORD_BITS-1:2*WORD_BITS] !== want.bias)
                        report_mismatch("bias", m_tdata[3*WORD_BITS-1:2*WORD_BITS], want.bias);
                end
                est_count++;
            end
            if (m_gap > 0 && !calm) begin
                m_gap--;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                m_gap = $urandom_range(1, 15);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any accepted request, estimate or register write.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || !aresetn) begin
            idle_count <= 0;
        end else if (idle_count >= STALL_LIMIT) begin
            $display("tilt_kalman_gyro_bias_unit test failed");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    task automatic write_setting(logic [CFG_IDX_BITS-1:0] idx, logic [FRAC_BITS:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        apply_setting(idx, val);
    endtask

    task automatic load_settings(logic [FRAC_BITS:0] dt, logic [FRAC_BITS:0] qa,
                                 logic [FRAC_BITS:0] qb, logic [FRAC_BITS:0] r);
        while (pending_reqs.size() > 0 || expected_estimates.size() > 0 || s_tvalid)
            @(posedge aclk);
        repeat (5) @(posedge aclk);
        write_setting(CFG_STEP_TIME, dt);
        write_setting(CFG_ANGLE_NOISE, qa);
        write_setting(CFG_BIAS_NOISE, qb);
        write_setting(CFG_MEAS_NOISE, r);
        cfg_valid <= 1'b0;
        phases++;
    endtask

    task automatic queue_req(logic cmd, logic [WORD_BITS-1:0] sample);
        sensor_req_t r;
        r.cmd = cmd;
        r.sample = sample;
        pending_reqs.push_back(r);
    endtask

    // Mostly plausible tracking sequences, with occasional full-range samples.
    task automatic queue_random(int n);
        logic [WORD_BITS-1:0] v;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0)
                v = $urandom();
            else
                v = WORD_BITS'($signed(int'($urandom_range(0, 1 << 26)) - (1 << 25)));
            queue_req(($urandom_range(0, 2) == 0) ? CMD_CORRECT : CMD_PREDICT, v);
        end
    endtask

    initial begin
        reset_filter();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extreme samples on both commands under the reset settings.
        queue_req(CMD_PREDICT, 32'h0000_0000);
        queue_req(CMD_CORRECT, 32'h0000_0000);
        queue_req(CMD_PREDICT, 32'h7FFF_FFFF);
        queue_req(CMD_PREDICT, 32'h7FFF_FFFF);
        queue_req(CMD_CORRECT, 32'h8000_0000);
        queue_req(CMD_PREDICT, 32'h8000_0000);
        queue_req(CMD_CORRECT, 32'h7FFF_FFFF);
        queue_req(CMD_PREDICT, 32'hFFFF_FFFF);
        queue_req(CMD_CORRECT, 32'hFFFF_FFFF);
        queue_req(CMD_CORRECT, 32'h0100_0000);
        for (int i = 0; i < 6; i++) queue_req(CMD_PREDICT, 32'h0100_0000);
        queue_req(CMD_CORRECT, 32'hFF00_0000);

        // Zero divisor: zero noise with the covariance driven to zero by a perfect fit.
        load_settings(25'd0, 25'd0, 25'd0, 25'd0);
        queue_req(CMD_CORRECT, 32'h0080_0000);
        queue_req(CMD_PREDICT, 32'h1234_5678);
        queue_req(CMD_CORRECT, 32'h0040_0000);
        queue_req(CMD_CORRECT, 32'hF000_0000);

        load_settings(25'h1000000, 25'h1000000, 25'h1000000, 25'd1);
        queue_random(150);
        load_settings(25'h1FFFFFF, 25'h1FFFFFF, 25'h1FFFFFF, 25'h1FFFFFF);
        queue_random(150);
        load_settings(25'd0, 25'd0, 25'd0, 25'd1);
        queue_random(100);
        for (int p = 0; p < 3; p++) begin
            load_settings(25'($urandom_range(1, 1 << 21)), 25'($urandom_range(0, 1 << 18)),
                          25'($urandom_range(0, 1 << 18)), 25'($urandom_range(1, 1 << 20)));
            queue_random(200);
        end
        load_settings(25'h0FFFFFF, 25'($urandom()), 25'($urandom()), 25'($urandom()));
        queue_random(100);

        // Final stretch with no idling on either side.
        load_settings(25'd335544, 25'd16777, 25'd25166, 25'd16777);
        calm = 1'b1;
        queue_random(100);

        while (pending_reqs.size() > 0 || expected_estimates.size() > 0 || s_tvalid)
            @(posedge aclk);
        repeat (300) @(posedge aclk);

        $display("Covered %0d requests (%0d corrections) and %0d estimates over %0d settings.",
                 req_count, corrections, est_count, phases);
        if (errors == 0 && expected_estimates.size() == 0) begin
            $display("tilt_kalman_gyro_bias_unit test passed");
        end else begin
            $display("tilt_kalman_gyro_bias_unit test failed");
        end
        $finish;
    end

    always @(posedge aclk) begin
        if (s_tvalid && s_tready && s_tuser == CMD_CORRECT) corrections <= corrections + 1;
    end
endmodule
